// ----- sv/csvt_pkg.sv -----
// Shared constants, types and helpers for the CSV field tokenizer.
`timescale 1ns / 1ps
package csvt_pkg;

    localparam int unsigned HOLD_DEPTH_DEFAULT = 16;

    localparam logic [7:0] QUOTE_BYTE  = 8'h22;
    localparam logic [7:0] DELIM_RESET = 8'd44;
    localparam logic [7:0] SPACE_BYTE  = 8'h20;
    localparam logic [7:0] TAB_BYTE    = 8'h09;
    localparam logic [7:0] CR_BYTE     = 8'h0D;

    // Word index of the delimiter register on the APB port.
    localparam logic REG_FIELD_DELIM = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FLUSH = 3'b010,
        ST_FINAL = 3'b100
    } csvt_state_t;

    typedef struct packed {
        logic accept;       // take the offered request and update parse state
        logic start_flush;  // request needs held whitespace sent first
        logic emit_held;    // load the next held byte into the output register
        logic advance;      // step to the following held byte
        logic emit_saved;   // load the byte that ended the flush
    } csvt_cmd_t;

    typedef struct packed {
        logic out_free;     // output register can take a result this cycle
        logic needs_flush;  // offered request releases held whitespace
        logic at_last;      // current held byte is the final one
    } csvt_status_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == SPACE_BYTE) || ((c >= TAB_BYTE) && (c <= CR_BYTE));
    endfunction

endpackage

// ----- sv/csv_field_tokenizer.sv -----
// Top level of the CSV field tokenizer: APB register, controller and datapath.
// Output: a result that needs no flush is in the output register in the cycle after its request is accepted.
// Throughput: one request per cycle when it releases no held whitespace; a content byte that
// releases held whitespace bytes keeps the block busy while they are sent one by one from the
// single read port of the hold memory, then the byte itself. Output stall backs up into in_stall.
// Reset: rst_n clears parse state and the output valid flag, and sets the delimiter to a comma.
`timescale 1ns / 1ps
module csv_field_tokenizer
    import csvt_pkg::*;
#(
    parameter int unsigned HOLD_DEPTH = HOLD_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        is_end_of_line,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        field_end,
    output logic        line_end,
    output logic        hold_overflow,
    output logic        last_of_run
);

    logic [7:0]   field_delim_reg;
    csvt_cmd_t    cmd;
    csvt_status_t st;

    // The delimiter register lives at word 0; byte-offset bits are ignored.
    // Write only while idle, so no interlock against a request in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_delim_reg <= DELIM_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_FIELD_DELIM))
        begin
            field_delim_reg <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FIELD_DELIM) ? {24'd0, field_delim_reg} : 32'd0;

    // Controller: decides when to accept a request and sequences the flush
    // of held whitespace ahead of the content byte that releases it.
    csvt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath: quote and trim logic, hold memory, output register.
    csvt_dp #(
        .HOLD_DEPTH (HOLD_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .field_delim    (field_delim_reg),
        .data_byte      (data_byte),
        .is_end_of_line (is_end_of_line),
        .out_stall      (out_stall),
        .cmd            (cmd),
        .st             (st),
        .out_valid      (out_valid),
        .out_byte       (out_byte),
        .byte_valid     (byte_valid),
        .field_end      (field_end),
        .line_end       (line_end),
        .hold_overflow  (hold_overflow),
        .last_of_run    (last_of_run)
    );

endmodule

// ----- sv/csvt_ctrl.sv -----
// Controller state machine for the CSV field tokenizer.
`timescale 1ns / 1ps
module csvt_ctrl
    import csvt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  csvt_status_t st,
    output csvt_cmd_t    cmd
);

    csvt_state_t state_reg;
    csvt_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall   = !st.out_free;
                cmd.accept = in_valid && st.out_free;
                if (cmd.accept && st.needs_flush)
                begin
                    cmd.start_flush = 1'b1;
                    state_next      = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (st.out_free)
                begin
                    cmd.emit_held = 1'b1;
                    if (st.at_last)
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            ST_FINAL:
            begin
                if (st.out_free)
                begin
                    cmd.emit_saved = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/csvt_dp.sv -----
// Datapath: parse state, whitespace hold memory and output register.
`timescale 1ns / 1ps
module csvt_dp
    import csvt_pkg::*;
#(
    parameter int unsigned HOLD_DEPTH = HOLD_DEPTH_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [7:0]   field_delim,
    input  logic [7:0]   data_byte,
    input  logic         is_end_of_line,
    input  logic         out_stall,
    input  csvt_cmd_t    cmd,
    output csvt_status_t st,
    output logic         out_valid,
    output logic [7:0]   out_byte,
    output logic         byte_valid,
    output logic         field_end,
    output logic         line_end,
    output logic         hold_overflow,
    output logic         last_of_run
);

    localparam int unsigned AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int unsigned CW = $clog2(HOLD_DEPTH + 1);

    // Parse state
    logic          inside_quotes_reg;
    logic          inside_quotes_next;
    logic          quote_pending_reg;
    logic          quote_pending_next;
    logic          has_content_reg;
    logic          has_content_next;
    logic [CW-1:0] held_count_reg;
    logic [CW-1:0] held_count_next;

    // Flush bookkeeping
    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] flush_end_reg;
    logic [7:0]    saved_byte_reg;

    // Hold memory
    logic [7:0]    held_mem [HOLD_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    // Decoded single result
    logic          res_load;
    logic [7:0]    res_byte;
    logic          res_bv;
    logic          res_fe;
    logic          res_le;
    logic          res_ov;
    logic          dec_flush;

    // Output register
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          byte_valid_reg;
    logic          field_end_reg;
    logic          line_end_reg;
    logic          overflow_reg;
    logic          last_reg;

    always_comb
    begin
        logic eff_inside;
        logic take;
        inside_quotes_next = inside_quotes_reg;
        quote_pending_next = quote_pending_reg;
        has_content_next   = has_content_reg;
        held_count_next    = held_count_reg;
        wr_en              = 1'b0;
        res_load           = 1'b0;
        res_byte           = 8'd0;
        res_bv             = 1'b0;
        res_fe             = 1'b0;
        res_le             = 1'b0;
        res_ov             = 1'b0;
        dec_flush          = 1'b0;
        eff_inside         = inside_quotes_reg;
        take               = 1'b0;
        if (is_end_of_line)
        begin
            res_load           = 1'b1;
            res_fe             = 1'b1;
            res_le             = 1'b1;
            inside_quotes_next = 1'b0;
            quote_pending_next = 1'b0;
            has_content_next   = 1'b0;
            held_count_next    = '0;
        end
        else
        begin
            if (quote_pending_reg)
            begin
                quote_pending_next = 1'b0;
                if (data_byte == QUOTE_BYTE)
                begin
                    take = 1'b1;
                end
                else
                begin
                    eff_inside         = 1'b0;
                    inside_quotes_next = 1'b0;
                end
            end
            if (!take)
            begin
                if (data_byte == QUOTE_BYTE)
                begin
                    if (eff_inside)
                    begin
                        quote_pending_next = 1'b1;
                    end
                    else
                    begin
                        inside_quotes_next = 1'b1;
                    end
                end
                else if (data_byte == field_delim && !eff_inside)
                begin
                    res_load         = 1'b1;
                    res_fe           = 1'b1;
                    has_content_next = 1'b0;
                    held_count_next  = '0;
                end
                else
                begin
                    take = 1'b1;
                end
            end
            if (take)
            begin
                if (is_space(data_byte))
                begin
                    if (has_content_reg)
                    begin
                        if (held_count_reg < CW'(HOLD_DEPTH))
                        begin
                            wr_en           = 1'b1;
                            held_count_next = held_count_reg + CW'(1);
                        end
                        else
                        begin
                            res_load = 1'b1;
                            res_ov   = 1'b1;
                        end
                    end
                end
                else
                begin
                    has_content_next = 1'b1;
                    held_count_next  = '0;
                    if (held_count_reg != '0)
                    begin
                        dec_flush = 1'b1;
                    end
                    else
                    begin
                        res_load = 1'b1;
                        res_bv   = 1'b1;
                        res_byte = data_byte;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_quotes_reg <= 1'b0;
            quote_pending_reg <= 1'b0;
            has_content_reg   <= 1'b0;
            held_count_reg    <= '0;
            rd_idx_reg        <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                inside_quotes_reg <= inside_quotes_next;
                quote_pending_reg <= quote_pending_next;
                has_content_reg   <= has_content_next;
                held_count_reg    <= held_count_next;
            end
            if (cmd.start_flush)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.advance)
            begin
                rd_idx_reg <= rd_idx_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_flush)
        begin
            flush_end_reg  <= AW'(held_count_reg - CW'(1));
            saved_byte_reg <= data_byte;
        end
    end

    assign rd_en   = cmd.start_flush || cmd.advance;
    assign rd_addr = cmd.start_flush ? '0 : rd_idx_reg + AW'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
        begin
            held_mem[held_count_reg[AW-1:0]] <= data_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= held_mem[rd_addr];
        end
    end

    assign st.out_free    = !out_valid_reg || !out_stall;
    assign st.needs_flush = dec_flush;
    assign st.at_last     = (rd_idx_reg == flush_end_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cmd.accept && res_load) || cmd.emit_held || cmd.emit_saved)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && res_load)
        begin
            out_byte_reg   <= res_byte;
            byte_valid_reg <= res_bv;
            field_end_reg  <= res_fe;
            line_end_reg   <= res_le;
            overflow_reg   <= res_ov;
            last_reg       <= 1'b1;
        end
        else if (cmd.emit_held)
        begin
            out_byte_reg   <= rd_data_reg;
            byte_valid_reg <= 1'b1;
            field_end_reg  <= 1'b0;
            line_end_reg   <= 1'b0;
            overflow_reg   <= 1'b0;
            last_reg       <= 1'b0;
        end
        else if (cmd.emit_saved)
        begin
            out_byte_reg   <= saved_byte_reg;
            byte_valid_reg <= 1'b1;
            field_end_reg  <= 1'b0;
            line_end_reg   <= 1'b0;
            overflow_reg   <= 1'b0;
            last_reg       <= 1'b1;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign byte_valid    = byte_valid_reg;
    assign field_end     = field_end_reg;
    assign line_end      = line_end_reg;
    assign hold_overflow = overflow_reg;
    assign last_of_run   = last_reg;

endmodule

// ----- sv/csvt_chk.sv -----
// Port-level checker for the CSV field tokenizer, bound to the top level.
`timescale 1ns / 1ps
module csvt_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  out_byte,
    input logic        byte_valid,
    input logic        field_end,
    input logic        line_end,
    input logic        hold_overflow,
    input logic        last_of_run
);

    // Hold a stalled result steady.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(field_end))
        else $error("stalled result changed");

    // A field end carries no byte and always closes the request's results.
    a_fend_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_end |-> !byte_valid && !hold_overflow && last_of_run)
        else $error("field end mixed with other result kinds");

    // A line end only comes with a field end.
    a_lend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_end |-> field_end)
        else $error("line end without field end");

    // An overflow result is alone and final for its request.
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hold_overflow |-> !byte_valid && last_of_run)
        else $error("overflow result malformed");

endmodule

bind csv_field_tokenizer csvt_chk u_csvt_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .field_end     (field_end),
    .line_end      (line_end),
    .hold_overflow (hold_overflow),
    .last_of_run   (last_of_run)
);
